/* hdl/bfsp_pkg.sv */
package bfsp_pkg;

  // Operation codes carried by an input item.
  localparam logic [1:0] OP_WRITE      = 2'd0;
  localparam logic [1:0] OP_READ       = 2'd1;
  localparam logic [1:0] OP_SET_CURSOR = 2'd2;

  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned CURSOR_MAX = 65535;

  // Field counts above one word act as one word.
  localparam logic [5:0] COUNT_MAX = 6'd32;

  // One result item as it waits in the output queue.
  typedef struct packed {
    logic [31:0] read_value;
    logic [15:0] cursor_after;
    logic        overflow;
  } out_item_t;

  // Mask of the low n bits, n from 0 to 32.
  function automatic logic [31:0] low_mask(input logic [5:0] n);
    logic [32:0] m;
    m = (33'd1 << n) - 33'd1;
    return m[31:0];
  endfunction

endpackage

/* hdl/bfsp_in_if.sv */
interface bfsp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] value;
  logic [5:0]  bit_count;
  logic [5:0]  extend_to;
  logic [15:0] position;

  modport source (output valid, operation, value, bit_count, extend_to, position,
                  input ready);
  modport sink   (input valid, operation, value, bit_count, extend_to, position,
                  output ready);
endinterface

/* hdl/bfsp_out_if.sv */
interface bfsp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic [15:0] cursor_after;
  logic        overflow;

  modport source (output valid, read_value, cursor_after, overflow, input ready);
  modport sink   (input valid, read_value, cursor_after, overflow, output ready);
endinterface

/* hdl/bit_field_stream_packer_top.sv */
// Bit stream packer over STORE_WORDS words of 32 bits, addressed by a bit cursor
// least significant bit first. Each item writes or reads a field of 1 to 32 bits
// at the cursor and advances it, or moves the cursor. The block takes one item
// per clock cycle while results are taken. The words under the cursor are read
// from two banks (even and odd words) in the cycle the item is accepted, and the
// next cycle merges the field and writes back the word under the cursor, and the
// word after it too when the field straddles a word boundary, so such a field is
// handled in the same pass as any other. The last write of each bank is forwarded
// to the item right behind it. A result item goes from the merge stage into the
// output queue, and up to three results queue at the output. An access past the
// end of the store, or a cursor beyond it, returns overflow and changes nothing.
// The store is not cleared after reset; the cursor returns to zero and the queue empties.
module bit_field_stream_packer_top #(
  parameter int STORE_WORDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfsp_in_if.sink     in_i,
  bfsp_out_if.source  out_o
);

  // Usable length in bits, capped so that the cursor fits in 16 bits.
  localparam int unsigned TOTAL_BITS = STORE_WORDS * bfsp_pkg::WORD_BITS;
  localparam int unsigned LIMIT_BITS =
    (TOTAL_BITS > bfsp_pkg::CURSOR_MAX) ? bfsp_pkg::CURSOR_MAX : TOTAL_BITS;
  localparam logic [16:0] LIMIT_C = 17'(LIMIT_BITS);
  localparam int unsigned USED_WORDS = (LIMIT_BITS + 31) / 32;
  localparam int BANK_DEPTH = USED_WORDS / 2 + 1;
  localparam int BANK_AW = $clog2(BANK_DEPTH);

  localparam logic [1:0] QDEPTH = 2'd3;

  logic        accept;
  logic [15:0] cursor_q, cursor_d;
  logic [5:0]  count_c, ext_c;
  logic [16:0] sum_c;
  logic        ovf_c, write_c, read_c;
  logic [10:0] idx_c;
  logic [11:0] even_full_c, odd_full_c;

  // Stage after the memory read.
  logic               s1_valid_q;
  logic               s1_write_q, s1_read_q, s1_odd_q, s1_ovf_q;
  logic [4:0]         s1_sh_q;
  logic [5:0]         s1_count_q, s1_ext_q;
  logic [31:0]        s1_value_q;
  logic [15:0]        s1_cursor_q;
  logic [BANK_AW-1:0] s1_even_addr_q, s1_odd_addr_q;

  logic [BANK_AW-1:0] even_raddr, odd_raddr;
  logic [31:0]        even_rdata, odd_rdata, even_data, odd_data;
  logic               even_we, odd_we;
  logic [31:0]        even_wdata, odd_wdata;

  // Last write of each bank, forwarded to the following item.
  logic               ewr_valid_q, owr_valid_q;
  logic [BANK_AW-1:0] ewr_addr_q, owr_addr_q;
  logic [31:0]        ewr_data_q, owr_data_q;

  logic [31:0] lo_word, hi_word, fmask, field, ext_mask, read_value;
  logic [63:0] win, place, mmask, new_win;
  logic [6:0]  end_bit;
  logic        straddle, sign_bit;
  logic [5:0]  count_m1;

  // Output queue.
  bfsp_pkg::out_item_t q_mem_q [3];
  logic [1:0] q_head_q, q_tail_q, q_cnt_q;
  logic       push, pop;
  logic [2:0] occupancy;

  assign occupancy = {1'b0, q_cnt_q} + {2'b0, s1_valid_q};
  assign in_i.ready = (occupancy < {1'b0, QDEPTH});
  assign accept = in_i.valid && in_i.ready;

  // Cursor update and overflow check at acceptance.
  always_comb begin
    count_c  = (in_i.bit_count > bfsp_pkg::COUNT_MAX) ? bfsp_pkg::COUNT_MAX : in_i.bit_count;
    ext_c    = (in_i.extend_to > bfsp_pkg::COUNT_MAX) ? bfsp_pkg::COUNT_MAX : in_i.extend_to;
    sum_c    = {1'b0, cursor_q} + {11'd0, count_c};
    cursor_d = cursor_q;
    ovf_c    = 1'b0;
    write_c  = 1'b0;
    read_c   = 1'b0;
    case (in_i.operation)
      bfsp_pkg::OP_SET_CURSOR: begin
        if ({1'b0, in_i.position} > LIMIT_C) begin
          ovf_c = 1'b1;
        end else begin
          cursor_d = in_i.position;
        end
      end
      bfsp_pkg::OP_WRITE, bfsp_pkg::OP_READ: begin
        if (sum_c > LIMIT_C) begin
          ovf_c = 1'b1;
        end else if (count_c != 6'd0) begin
          cursor_d = sum_c[15:0];
          write_c  = (in_i.operation == bfsp_pkg::OP_WRITE);
          read_c   = (in_i.operation == bfsp_pkg::OP_READ);
        end
      end
      default: begin
        cursor_d = cursor_q;
      end
    endcase
  end

  // Word index under the cursor and its two bank addresses.
  assign idx_c       = cursor_q[15:5];
  assign even_full_c = ({1'b0, idx_c} + 12'd1) >> 1;
  assign odd_full_c  = {1'b0, idx_c} >> 1;
  assign even_raddr  = even_full_c[BANK_AW-1:0];
  assign odd_raddr   = odd_full_c[BANK_AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q   <= 16'd0;
      s1_valid_q <= 1'b0;
      s1_write_q <= 1'b0;
      s1_read_q  <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        cursor_q   <= cursor_d;
        s1_write_q <= write_c;
        s1_read_q  <= read_c;
      end else begin
        s1_write_q <= 1'b0;
        s1_read_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_odd_q       <= idx_c[0];
      s1_ovf_q       <= ovf_c;
      s1_sh_q        <= cursor_q[4:0];
      s1_count_q     <= count_c;
      s1_ext_q       <= ext_c;
      s1_value_q     <= in_i.value;
      s1_cursor_q    <= cursor_d;
      s1_even_addr_q <= even_raddr;
      s1_odd_addr_q  <= odd_raddr;
    end
  end

  bfsp_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_even_ram (
    .clk_i   (clk_i),
    .we_i    (even_we),
    .waddr_i (s1_even_addr_q),
    .wdata_i (even_wdata),
    .raddr_i (even_raddr),
    .rdata_o (even_rdata)
  );

  bfsp_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_odd_ram (
    .clk_i   (clk_i),
    .we_i    (odd_we),
    .waddr_i (s1_odd_addr_q),
    .wdata_i (odd_wdata),
    .raddr_i (odd_raddr),
    .rdata_o (odd_rdata)
  );

  // Forward a write that landed in the same cycle as this item's read.
  assign even_data = (ewr_valid_q && (ewr_addr_q == s1_even_addr_q)) ? ewr_data_q : even_rdata;
  assign odd_data  = (owr_valid_q && (owr_addr_q == s1_odd_addr_q)) ? owr_data_q : odd_rdata;

  // Merge or extract the field in the 64-bit window.
  always_comb begin
    lo_word  = s1_odd_q ? odd_data : even_data;
    hi_word  = s1_odd_q ? even_data : odd_data;
    win      = {hi_word, lo_word};
    fmask    = bfsp_pkg::low_mask(s1_count_q);
    place    = {32'd0, s1_value_q & fmask} << s1_sh_q;
    mmask    = {32'd0, fmask} << s1_sh_q;
    new_win  = (win & ~mmask) | place;
    end_bit  = {2'b0, s1_sh_q} + {1'b0, s1_count_q};
    straddle = (end_bit > 7'd32);

    even_we    = s1_write_q && (s1_odd_q ? straddle : 1'b1);
    odd_we     = s1_write_q && (s1_odd_q ? 1'b1 : straddle);
    even_wdata = s1_odd_q ? new_win[63:32] : new_win[31:0];
    odd_wdata  = s1_odd_q ? new_win[31:0] : new_win[63:32];

    count_m1 = s1_count_q - 6'd1;
    field    = 32'(win >> s1_sh_q) & fmask;
    sign_bit = field[count_m1[4:0]];
    ext_mask = bfsp_pkg::low_mask(s1_ext_q) & ~fmask;
    if ((s1_ext_q > s1_count_q) && sign_bit) begin
      field = field | ext_mask;
    end
    read_value = s1_read_q ? field : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ewr_valid_q <= 1'b0;
      owr_valid_q <= 1'b0;
    end else begin
      ewr_valid_q <= even_we;
      owr_valid_q <= odd_we;
    end
  end

  always_ff @(posedge clk_i) begin
    ewr_addr_q <= s1_even_addr_q;
    ewr_data_q <= even_wdata;
    owr_addr_q <= s1_odd_addr_q;
    owr_data_q <= odd_wdata;
  end

  // Output queue of three items.
  assign push = s1_valid_q;
  assign pop  = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_head_q <= 2'd0;
      q_tail_q <= 2'd0;
      q_cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        q_tail_q <= (q_tail_q == 2'd2) ? 2'd0 : q_tail_q + 2'd1;
      end
      if (pop) begin
        q_head_q <= (q_head_q == 2'd2) ? 2'd0 : q_head_q + 2'd1;
      end
      if (push && !pop) begin
        q_cnt_q <= q_cnt_q + 2'd1;
      end else if (pop && !push) begin
        q_cnt_q <= q_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[q_tail_q] <= '{read_value:   read_value,
                             cursor_after: s1_cursor_q,
                             overflow:     s1_ovf_q};
    end
  end

  assign out_o.valid        = (q_cnt_q != 2'd0);
  assign out_o.read_value   = q_mem_q[q_head_q].read_value;
  assign out_o.cursor_after = q_mem_q[q_head_q].cursor_after;
  assign out_o.overflow     = q_mem_q[q_head_q].overflow;

endmodule

/* hdl/bfsp_ram.sv */
module bfsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read that returns the old data on a collision.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* dv/bfsp_result_checker.sv */
module bfsp_result_checker
  import bfsp_pkg::*;
#(
  parameter int STORE_WORDS = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  bfsp_in_if   in_mon,
  bfsp_out_if  out_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   results_o,
  output int   writes_o,
  output int   reads_o,
  output int   overflows_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Usable stream length in bits; the cursor must fit in 16 bits.
  localparam int unsigned LIMIT_BITS =
    (STORE_WORDS * WORD_BITS > CURSOR_MAX) ? CURSOR_MAX : STORE_WORDS * WORD_BITS;

  // Shadow of the packed word store and of the bit cursor.
  bit   [31:0] packed_words [STORE_WORDS];
  logic [15:0] stream_cursor;

  // Results predicted for accepted items, oldest first.
  out_item_t awaited_results [$];

  // Applies one item to the shadow store and returns the result it should produce.
  function automatic out_item_t apply_field_access(input logic [1:0]  op,
                                                   input logic [31:0] value,
                                                   input logic [5:0]  bit_count,
                                                   input logic [5:0]  extend_to,
                                                   input logic [15:0] position);
    out_item_t   res;
    int unsigned cnt;
    int unsigned ext;
    int unsigned idx;
    int unsigned sh;
    logic [63:0] win;
    logic [63:0] fmask;
    logic [63:0] field;
    res = '0;
    cnt = (bit_count > COUNT_MAX) ? WORD_BITS : bit_count;
    ext = (extend_to > COUNT_MAX) ? WORD_BITS : extend_to;
    case (op)
      OP_SET_CURSOR: begin
        if (position > LIMIT_BITS) res.overflow = 1'b1;
        else stream_cursor = position;
      end
      OP_WRITE, OP_READ: begin
        if (stream_cursor + cnt > LIMIT_BITS) begin
          res.overflow = 1'b1;
        end else if (cnt != 0) begin
          // Two-word window under the cursor; words past the store read as zero.
          idx = stream_cursor >> 5;
          sh = stream_cursor[4:0];
          fmask = (64'd1 << cnt) - 64'd1;
          win = '0;
          if (idx < STORE_WORDS) win[31:0] = packed_words[idx];
          if (idx + 1 < STORE_WORDS) win[63:32] = packed_words[idx + 1];
          if (op == OP_WRITE) begin
            win = (win & ~(fmask << sh)) | (({32'd0, value} & fmask) << sh);
            if (idx < STORE_WORDS) packed_words[idx] = win[31:0];
            if (idx + 1 < STORE_WORDS) packed_words[idx + 1] = win[63:32];
          end else begin
            field = (win >> sh) & fmask;
            // A set top bit fills the bits up to the extension width.
            if (ext > cnt && field[cnt - 1]) begin
              field = field | (((64'd1 << ext) - 64'd1) & ~fmask);
            end
            res.read_value = field[31:0];
          end
          stream_cursor = stream_cursor + 16'(cnt);
        end
      end
      default: ;
    endcase
    res.cursor_after = stream_cursor;
    return res;
  endfunction

  // Predict on every accepted input item, compare on every accepted result item.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      stream_cursor = '0;
      awaited_results.delete();
      fail_count_o = 0;
      pending_o = 0;
      results_o = 0;
      writes_o = 0;
      reads_o = 0;
      overflows_o = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        want = apply_field_access(in_mon.operation, in_mon.value, in_mon.bit_count,
                                  in_mon.extend_to, in_mon.position);
        awaited_results.push_back(want);
        if (want.overflow) overflows_o++;
        else if (in_mon.operation == OP_WRITE) writes_o++;
        else if (in_mon.operation == OP_READ) reads_o++;
      end
      if (out_mon.valid && out_mon.ready) begin
        got.read_value = out_mon.read_value;
        got.cursor_after = out_mon.cursor_after;
        got.overflow = out_mon.overflow;
        results_o++;
        if (awaited_results.size() == 0) begin
          $display("%0t: result item with none expected: read_value %h cursor %0d overflow %b",
                   $time, got.read_value, got.cursor_after, got.overflow);
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          if (got.read_value !== want.read_value) begin
            $display("%0t: read_value expected %h, got %h",
                     $time, want.read_value, got.read_value);
            fail_count_o++;
          end
          if (got.cursor_after !== want.cursor_after) begin
            $display("%0t: cursor_after expected %0d, got %0d",
                     $time, want.cursor_after, got.cursor_after);
            fail_count_o++;
          end
          if (got.overflow !== want.overflow) begin
            $display("%0t: overflow expected %b, got %b", $time, want.overflow, got.overflow);
            fail_count_o++;
          end
        end
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

/* dv/bit_field_stream_packer_top_test.sv */
module bit_field_stream_packer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bfsp_pkg::*;

  localparam int          STORE_WORDS  = 1024;
  localparam int unsigned LIMIT_BITS   =
    (STORE_WORDS * WORD_BITS > CURSOR_MAX) ? CURSOR_MAX : STORE_WORDS * WORD_BITS;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          ITEM_TARGET  = 1400;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          TIMEOUT_NS   = 5_000_000;

  logic clk_i;
  logic rst_ni;

  bfsp_in_if  in_ch ();
  bfsp_out_if out_ch ();

  int fail_count;
  int pending;
  int results;
  int writes;
  int reads;
  int overflows;

  // Stimulus bookkeeping: where the cursor will be and which bits hold data.
  int unsigned plan_cursor;
  bit          written_bits [LIMIT_BITS];
  int          items_sent;
  bit          idle_on;
  bit          hold_request;

  bit_field_stream_packer_top #(
    .STORE_WORDS(STORE_WORDS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  bfsp_result_checker #(
    .STORE_WORDS(STORE_WORDS)
  ) result_watch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results),
    .writes_o    (writes),
    .reads_o     (reads),
    .overflows_o (overflows)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Offers one item and waits for it to be accepted. A read of bits that hold
  // no data yet is turned into a write of the same field.
  task automatic send_item(input logic [1:0]  op,
                           input logic [31:0] value,
                           input logic [5:0]  bit_count,
                           input logic [5:0]  extend_to,
                           input logic [15:0] position);
    int unsigned cnt;
    int unsigned gap;
    cnt = (bit_count > COUNT_MAX) ? WORD_BITS : bit_count;
    if (op == OP_READ && cnt != 0 && plan_cursor + cnt <= LIMIT_BITS) begin
      for (int b = 0; b < cnt; b++) begin
        if (!written_bits[plan_cursor + b]) op = OP_WRITE;
      end
    end
    case (op)
      OP_SET_CURSOR: begin
        if (position <= LIMIT_BITS) plan_cursor = position;
      end
      OP_WRITE, OP_READ: begin
        if (plan_cursor + cnt <= LIMIT_BITS) begin
          if (op == OP_WRITE) begin
            for (int b = 0; b < cnt; b++) written_bits[plan_cursor + b] = 1'b1;
          end
          plan_cursor = plan_cursor + cnt;
        end
      end
      default: ;
    endcase
    gap = (idle_on && !hold_request) ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.value <= value;
    in_ch.bit_count <= bit_count;
    in_ch.extend_to <= extend_to;
    in_ch.position <= position;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // Field widths: mostly 1 to 32, sometimes zero or above a word.
  function automatic logic [5:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return 6'd0;
    if (r < 10) return 6'($urandom_range(33, 63));
    return 6'($urandom_range(1, 32));
  endfunction

  // Stream start points: word aligned, anywhere, or close to either end.
  function automatic logic [15:0] pick_start();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, STORE_WORDS - 1) * WORD_BITS);
      1: return 16'($urandom_range(0, LIMIT_BITS - 1));
      2: return 16'(LIMIT_BITS - $urandom_range(0, 300));
      default: return 16'($urandom_range(0, 300));
    endcase
  endfunction

  // Packs a run of fields from one start point, then rewinds and unpacks them.
  task automatic run_stream();
    logic [5:0]  widths [8];
    logic [15:0] start;
    int unsigned n;
    n = $urandom_range(1, 8);
    start = pick_start();
    send_item(OP_SET_CURSOR, $urandom, 6'($urandom), 6'($urandom), start);
    for (int i = 0; i < n; i++) begin
      widths[i] = pick_count();
      send_item(OP_WRITE, $urandom, widths[i], 6'($urandom), 16'($urandom));
    end
    send_item(OP_SET_CURSOR, $urandom, 6'($urandom), 6'($urandom), start);
    for (int i = 0; i < n; i++) begin
      send_item(OP_READ, $urandom, widths[i], 6'($urandom_range(0, 63)), 16'($urandom));
    end
  endtask

  // One unstructured item, positions often out of range.
  task automatic run_noise();
    logic [15:0] pos;
    pos = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, LIMIT_BITS));
    send_item(2'($urandom), $urandom, pick_count(), 6'($urandom), pos);
  endtask

  // Result side: a random pause before each item, and one long hold on request.
  initial begin
    int unsigned pause;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        pause = idle_on ? $urandom_range(0, 15) : 0;
        if (pause != 0) begin
          out_ch.ready <= 1'b0;
          repeat (pause) @(posedge clk_i);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // Stimulus and verdict.
  initial begin
    bit pressure_done;
    pressure_done = 1'b0;
    plan_cursor = 0;
    items_sent = 0;
    idle_on = 1'b1;
    hold_request = 1'b0;
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_WRITE;
    in_ch.value <= '0;
    in_ch.bit_count <= '0;
    in_ch.extend_to <= '0;
    in_ch.position <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero-width accesses touch nothing, even before any data exists.
    send_item(OP_READ, 32'hFFFF_FFFF, 6'd0, 6'd63, 16'd0);
    send_item(OP_WRITE, 32'hFFFF_FFFF, 6'd0, 6'd0, 16'd0);
    // Full word, a single bit with the upper value bits masked off, a field that
    // straddles two words, and a width above a word.
    send_item(OP_WRITE, 32'hFFFF_FFFF, 6'd32, 6'd0, 16'd0);
    send_item(OP_WRITE, 32'hFFFF_FFFE, 6'd1, 6'd0, 16'd0);
    send_item(OP_WRITE, 32'hA5A5_5A5A, 6'd32, 6'd0, 16'd0);
    send_item(OP_WRITE, 32'h1234_5678, 6'd40, 6'd0, 16'd0);
    // The unused operation code does nothing.
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 6'd63, 6'd63, 16'hFFFF);
    // Read the same fields back, with and without extension.
    send_item(OP_SET_CURSOR, 32'd0, 6'd0, 6'd0, 16'd0);
    send_item(OP_READ, 32'd0, 6'd32, 6'd0, 16'd0);
    send_item(OP_READ, 32'd0, 6'd1, 6'd32, 16'd0);
    send_item(OP_READ, 32'd0, 6'd32, 6'd63, 16'd0);
    send_item(OP_READ, 32'd0, 6'd63, 6'd0, 16'd0);
    // Sign extension of a short field, and an extension width below the count.
    send_item(OP_SET_CURSOR, 32'd0, 6'd0, 6'd0, 16'd0);
    send_item(OP_READ, 32'd0, 6'd4, 6'd32, 16'd0);
    send_item(OP_READ, 32'd0, 6'd3, 6'd2, 16'd0);
    // Store end: cursor beyond it, exactly at it, and accesses ending at it or running past it.
    send_item(OP_SET_CURSOR, 32'd0, 6'd0, 6'd0, 16'hFFFF);
    send_item(OP_SET_CURSOR, 32'd0, 6'd0, 6'd0, 16'(LIMIT_BITS));
    send_item(OP_WRITE, 32'd1, 6'd1, 6'd0, 16'd0);
    send_item(OP_READ, 32'd0, 6'd0, 6'd32, 16'd0);
    send_item(OP_SET_CURSOR, 32'd0, 6'd0, 6'd0, 16'(LIMIT_BITS - 32));
    send_item(OP_WRITE, 32'h8000_0001, 6'd32, 6'd0, 16'd0);
    send_item(OP_SET_CURSOR, 32'd0, 6'd0, 6'd0, 16'(LIMIT_BITS - 31));
    send_item(OP_WRITE, 32'hFFFF_FFFF, 6'd32, 6'd0, 16'd0);
    send_item(OP_SET_CURSOR, 32'd0, 6'd0, 6'd0, 16'(LIMIT_BITS - 1));
    send_item(OP_READ, 32'd0, 6'd1, 6'd32, 16'd0);

    // Random part: mostly pack-and-unpack streams, some loose items.
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) idle_on = !idle_on;
      if (!pressure_done && items_sent >= ITEM_TARGET / 2) begin
        hold_request = 1'b1;
        pressure_done = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) begin
        run_stream();
      end else begin
        repeat ($urandom_range(1, 3)) run_noise();
      end
    end
    in_ch.valid <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Sent %0d items and checked %0d results.", items_sent, results);
    $display("Stored fields: %0d, fields read back: %0d, refused past the end: %0d.",
             writes, reads, overflows);
    if (fail_count == 0 && pending == 0) begin
      $display("bit_field_stream_packer_top_test OK");
    end else begin
      $display("bit_field_stream_packer_top_test NOT OK");
    end
    $finish;
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #(TIMEOUT_NS);
    $display("bit_field_stream_packer_top_test NOT OK");
    $finish;
  end

endmodule

/* files.f */
hdl/bfsp_pkg.sv
hdl/bfsp_in_if.sv
hdl/bfsp_out_if.sv
hdl/bfsp_ram.sv
hdl/bit_field_stream_packer_top.sv
dv/bfsp_result_checker.sv
dv/bit_field_stream_packer_top_test.sv
